[src/page_frame_bitmap_allocator_assert.svh]
// Assertion helpers for the page frame allocator
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define PFBA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PFBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/pfba_pkg.sv]
package pfba_pkg;

   localparam int ADDR_W      = 40;
   localparam int CMD_W       = 3;
   localparam int FRAME_OUT_W = 11;
   localparam int COUNT_W     = 20;
   localparam int CSR_IDX_W   = 1;

   localparam int MAP_WORDS_DEF  = 32;
   localparam int PAGE_SHIFT_DEF = 21;
   localparam int WORD_BITS_DEF  = 64;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [63:0] HOLE_LOW  = 64'h0000_0000_FEC0_0000;
   localparam logic [63:0] HOLE_HIGH = 64'h0000_0000_FFFF_FFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_END   = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_INIT       = 3'd0,
      CMD_ADD_RANGE  = 3'd1,
      CMD_ALLOC      = 3'd2,
      CMD_FREE_ADDR  = 3'd3,
      CMD_FREE_FRAME = 3'd4
   } cmd_type;

endpackage

[src/pfba_map.sv]
module pfba_map #(
   parameter int WORDS = pfba_pkg::MAP_WORDS_DEF,
   parameter int WIDTH = pfba_pkg::WORD_BITS_DEF,
   parameter int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic             clock,
   input  logic [AW-1:0]    rd_addr,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);
   import pfba_pkg::*;

   logic [WIDTH-1:0] map_mem [WORDS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/pfba_div.sv]
module pfba_div #(
   parameter int FW        = 11,
   parameter int WORD_BITS = pfba_pkg::WORD_BITS_DEF,
   parameter int AW        = 5,
   parameter int BW        = $clog2(WORD_BITS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [FW-1:0] value,
   output logic          done,
   output logic [AW-1:0] quotient,
   output logic [BW-1:0] remainder
);
   import pfba_pkg::*;

   // word/bit split by reciprocal multiply; exact for every FW-bit value
   localparam int SH = FW + BW;
   localparam int PW = FW + SH + 1;
   localparam logic [SH:0] RECIP =
      (SH+1)'(((64'd1 << SH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

   logic          done_ff, done_in;
   logic [FW-1:0] q_ff, q_in;
   logic [BW-1:0] r_ff, r_in;

   logic [PW-1:0] prod;
   logic [FW-1:0] q_calc;

   always_comb begin
      prod    = PW'(value) * PW'(RECIP);
      q_calc  = FW'(prod >> SH);
      done_in = start;
      q_in    = start ? q_calc : q_ff;
      r_in    = start ? BW'(value - FW'(32'(q_calc) * WORD_BITS)) : r_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign done      = done_ff;
   assign quotient  = AW'(q_ff);
   assign remainder = r_ff;

endmodule

[src/page_frame_bitmap_allocator.sv]
// Bitmap page frame allocator; one request at a time, one result strobe per request.
// Allocate scans one map word per cycle; a free outside the map and an unknown command are
// answered without touching the map. Add range walks the range page by page, with an extra
// clear step for each usable page inside the map. Results cannot be stalled.
// Synchronous reset clears the control registers and runs a pass marking every map word busy.
`include "page_frame_bitmap_allocator_assert.svh"

module page_frame_bitmap_allocator #(
   parameter int MAP_WORDS  = pfba_pkg::MAP_WORDS_DEF,
   parameter int PAGE_SHIFT = pfba_pkg::PAGE_SHIFT_DEF,
   parameter int WORD_BITS  = pfba_pkg::WORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [pfba_pkg::CMD_W-1:0]        req_cmd,
   input  logic [pfba_pkg::ADDR_W-1:0]       req_range_base,
   input  logic [pfba_pkg::ADDR_W-1:0]       req_range_length,
   input  logic [pfba_pkg::FRAME_OUT_W-1:0]  req_frame_in,
   output logic                              rsp_valid,
   output logic [pfba_pkg::FRAME_OUT_W-1:0]  rsp_frame_out,
   output logic                              rsp_out_of_memory,
   output logic [pfba_pkg::COUNT_W-1:0]      rsp_pages_added,
   output logic [pfba_pkg::COUNT_W-1:0]      rsp_usable_total,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pfba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pfba_pkg::ADDR_W-1:0]       csr_wdata
);
   import pfba_pkg::*;

   localparam int FRAMES = MAP_WORDS * WORD_BITS;
   localparam int FW     = $clog2(FRAMES);
   localparam int AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BW     = $clog2(WORD_BITS);
   localparam int PNW    = ADDR_W + 1 - PAGE_SHIFT;
   localparam int SUMW   = ((PNW > COUNT_W) ? PNW : COUNT_W) + 1;
   localparam logic [ADDR_W:0] ROUND_UP = (ADDR_W+1)'((64'd1 << PAGE_SHIFT) - 64'd1);
   localparam logic [63:0] HOLE_LO_PN =
      (HOLE_LOW + (64'd1 << PAGE_SHIFT) - 64'd1) >> PAGE_SHIFT;
   localparam logic [63:0] HOLE_HI_PN =
      (HOLE_HIGH + (64'd1 << PAGE_SHIFT) - 64'd1) >> PAGE_SHIFT;
   localparam logic [WORD_BITS-1:0] ONE_BIT = WORD_BITS'(1);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_SWEEP = 9'b000000010,
      S_SETUP = 9'b000000100,
      S_DIVW  = 9'b000001000,
      S_PAGE  = 9'b000010000,
      S_CLR   = 9'b000100000,
      S_FDIV  = 9'b001000000,
      S_FWR   = 9'b010000000,
      S_ACHK  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]      ks_ff, ks_in, ke_ff, ke_in;
   logic [COUNT_W-1:0]     usable_ff, usable_in;
   logic [AW-1:0]          sw_ff, sw_in;
   logic                   sw_rsp_ff, sw_rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [ADDR_W-1:0]      base_ff, base_in, len_ff, len_in;
   logic [PNW-1:0]         pn_ff, pn_in, last_ff, last_in;
   logic [PNW-1:0]         ksc_ff, ksc_in, kec_ff, kec_in;
   logic [PNW-1:0]         n_ff, n_in;
   logic [AW-1:0]          wd_ff, wd_in;
   logic [BW-1:0]          bt_ff, bt_in;
   logic [AW-1:0]          aw_ff, aw_in;
   logic [FRAME_OUT_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic                   rsp_oom_ff, rsp_oom_in;
   logic [COUNT_W-1:0]     rsp_added_ff, rsp_added_in;
   logic [COUNT_W-1:0]     rsp_total_ff, rsp_total_in;

   logic                 accept;
   logic [PNW-1:0]       pn0, last_pn, ks_pn, ke_pn, pn1;
   logic [ADDR_W-PAGE_SHIFT-1:0] free_pn;
   logic                 kern_hit, hole_hit, page_ok, in_map, walk_done;
   logic [SUMW-1:0]      sum;
   logic [COUNT_W-1:0]   sum_sat;
   logic [WORD_BITS-1:0] bit_mask, free_bits, low_free;
   logic [BW-1:0]        zero_idx;
   logic                 word_full, aw_last, bt_last;
   logic [FW-1:0]        alloc_frame;

   logic                 div_start, div_done;
   logic [FW-1:0]        div_value;
   logic [AW-1:0]        div_q;
   logic [BW-1:0]        div_r;

   logic [AW-1:0]        map_rd_addr, map_wr_addr;
   logic                 map_wr_en;
   logic [WORD_BITS-1:0] map_wr_data, map_rd_data;

   pfba_map #(.WORDS(MAP_WORDS), .WIDTH(WORD_BITS), .AW(AW)) u_map (
      .clock   (clock),
      .rd_addr (map_rd_addr),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_data (map_rd_data)
   );

   pfba_div #(.FW(FW), .WORD_BITS(WORD_BITS), .AW(AW), .BW(BW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .value     (div_value),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // page-number thresholds: all compares in the walk are done in page units
   assign pn0     = PNW'(({1'b0, base_ff} + ROUND_UP) >> PAGE_SHIFT);
   assign last_pn = PNW'(({1'b0, base_ff} + {1'b0, len_ff}) >> PAGE_SHIFT);
   assign ks_pn   = PNW'(({1'b0, ks_ff} + ROUND_UP) >> PAGE_SHIFT);
   assign ke_pn   = PNW'(({1'b0, ke_ff} + ROUND_UP) >> PAGE_SHIFT);
   assign pn1     = pn_ff + 1'b1;
   assign free_pn = req_range_base[ADDR_W-1:PAGE_SHIFT];

   assign kern_hit  = (pn1 >= ksc_ff) && (pn_ff < kec_ff);
   assign hole_hit  = (64'(pn1) >= HOLE_LO_PN) && (64'(pn_ff) < HOLE_HI_PN);
   assign page_ok   = !kern_hit && !hole_hit;
   assign in_map    = 64'(pn_ff) < 64'(FRAMES);
   assign walk_done = !(pn_ff < last_ff);

   assign sum     = SUMW'(usable_ff) + SUMW'(n_ff);
   assign sum_sat = (sum > SUMW'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(sum);

   assign bit_mask  = ONE_BIT << bt_ff;
   assign free_bits = ~map_rd_data;
   assign low_free  = free_bits & (~free_bits + ONE_BIT);
   assign word_full = (free_bits == '0);
   assign aw_last   = (aw_ff == AW'(MAP_WORDS - 1));
   assign bt_last   = (bt_ff == BW'(WORD_BITS - 1));

   always_comb begin
      zero_idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (low_free[i]) begin
            zero_idx = zero_idx | BW'(i);
         end
      end
   end

   assign alloc_frame = FW'(32'(aw_ff) * WORD_BITS + 32'(zero_idx));

   always_comb begin
      state_in     = state_ff;
      ks_in        = ks_ff;
      ke_in        = ke_ff;
      usable_in    = usable_ff;
      sw_in        = sw_ff;
      sw_rsp_in    = sw_rsp_ff;
      rsp_valid_in = 1'b0;
      base_in      = base_ff;
      len_in       = len_ff;
      pn_in        = pn_ff;
      last_in      = last_ff;
      ksc_in       = ksc_ff;
      kec_in       = kec_ff;
      n_in         = n_ff;
      wd_in        = wd_ff;
      bt_in        = bt_ff;
      aw_in        = aw_ff;
      rsp_frame_in = rsp_frame_ff;
      rsp_oom_in   = rsp_oom_ff;
      rsp_added_in = rsp_added_ff;
      rsp_total_in = rsp_total_ff;
      div_start    = 1'b0;
      div_value    = FW'(pn0);
      map_rd_addr  = wd_ff;
      map_wr_en    = 1'b0;
      map_wr_addr  = wd_ff;
      map_wr_data  = map_rd_data & ~bit_mask;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KERNEL_START: ks_in = csr_wdata;
            CSR_KERNEL_END:   ke_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               base_in      = req_range_base;
               len_in       = req_range_length;
               rsp_frame_in = '0;
               rsp_oom_in   = 1'b0;
               rsp_added_in = '0;
               rsp_total_in = usable_ff;
               case (cmd_type'(req_cmd))
                  CMD_INIT: begin
                     sw_in     = '0;
                     sw_rsp_in = 1'b1;
                     usable_in = '0;
                     state_in  = S_SWEEP;
                  end
                  CMD_ADD_RANGE: begin
                     state_in = S_SETUP;
                  end
                  CMD_ALLOC: begin
                     map_rd_addr = '0;
                     aw_in       = '0;
                     state_in    = S_ACHK;
                  end
                  CMD_FREE_ADDR: begin
                     if (64'(free_pn) < 64'(FRAMES)) begin
                        div_start = 1'b1;
                        div_value = FW'(free_pn);
                        state_in  = S_FDIV;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  CMD_FREE_FRAME: begin
                     if (64'(req_frame_in) < 64'(FRAMES)) begin
                        div_start = 1'b1;
                        div_value = FW'(req_frame_in);
                        state_in  = S_FDIV;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            map_wr_en   = 1'b1;
            map_wr_addr = sw_ff;
            map_wr_data = '1;
            if (sw_ff == AW'(MAP_WORDS - 1)) begin
               state_in     = S_IDLE;
               sw_rsp_in    = 1'b0;
               rsp_valid_in = sw_rsp_ff;
               rsp_total_in = usable_ff;
            end else begin
               sw_in = sw_ff + 1'b1;
            end
         end
         S_SETUP: begin
            pn_in   = pn0;
            last_in = last_pn;
            ksc_in  = ks_pn;
            kec_in  = ke_pn;
            n_in    = '0;
            if (64'(pn0) < 64'(FRAMES)) begin
               div_start = 1'b1;
               state_in  = S_DIVW;
            end else begin
               state_in = S_PAGE;
            end
         end
         S_DIVW: begin
            if (div_done) begin
               wd_in    = div_q;
               bt_in    = div_r;
               state_in = S_PAGE;
            end
         end
         S_PAGE: begin
            if (walk_done) begin
               usable_in    = sum_sat;
               rsp_total_in = sum_sat;
               rsp_added_in = COUNT_W'(n_ff);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               if (page_ok) begin
                  n_in = n_ff + 1'b1;
               end
               if (page_ok && in_map) begin
                  // word read issued now, cleared and written back next cycle
                  state_in = S_CLR;
               end else begin
                  pn_in = pn1;
                  if (bt_last) begin
                     bt_in = '0;
                     wd_in = wd_ff + 1'b1;
                  end else begin
                     bt_in = bt_ff + 1'b1;
                  end
               end
            end
         end
         S_CLR: begin
            map_wr_en = 1'b1;
            pn_in     = pn1;
            if (bt_last) begin
               bt_in = '0;
               wd_in = wd_ff + 1'b1;
            end else begin
               bt_in = bt_ff + 1'b1;
            end
            state_in = S_PAGE;
         end
         S_FDIV: begin
            if (div_done) begin
               wd_in       = div_q;
               bt_in       = div_r;
               map_rd_addr = div_q;
               state_in    = S_FWR;
            end
         end
         S_FWR: begin
            map_wr_en    = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_ACHK: begin
            // check word aw_ff while the next word is being read
            map_rd_addr = aw_last ? '0 : aw_ff + 1'b1;
            if (!word_full) begin
               map_wr_en    = 1'b1;
               map_wr_addr  = aw_ff;
               map_wr_data  = map_rd_data | low_free;
               rsp_frame_in = FRAME_OUT_W'(alloc_frame);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (aw_last) begin
               rsp_oom_in   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               aw_in = aw_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         ks_ff        <= '0;
         ke_ff        <= '0;
         usable_ff    <= '0;
         sw_ff        <= '0;
         sw_rsp_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ks_ff        <= ks_in;
         ke_ff        <= ke_in;
         usable_ff    <= usable_in;
         sw_ff        <= sw_in;
         sw_rsp_ff    <= sw_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      len_ff       <= len_in;
      pn_ff        <= pn_in;
      last_ff      <= last_in;
      ksc_ff       <= ksc_in;
      kec_ff       <= kec_in;
      n_ff         <= n_in;
      wd_ff        <= wd_in;
      bt_ff        <= bt_in;
      aw_ff        <= aw_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_oom_ff   <= rsp_oom_in;
      rsp_added_ff <= rsp_added_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_out     = rsp_frame_ff;
   assign rsp_out_of_memory = rsp_oom_ff;
   assign rsp_pages_added   = rsp_added_ff;
   assign rsp_usable_total  = rsp_total_ff;

   `PFBA_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_valid, "accepted request neither in progress nor answered")
   `PFBA_ASSERT_IMPLY(a_rsp_when_idle, clock, reset, rsp_valid, !busy, "result shown while still busy")
   `PFBA_ASSERT_IMPLY(a_oom_fields, clock, reset, rsp_valid && rsp_out_of_memory, (rsp_frame_out == '0) && (rsp_pages_added == '0), "out of memory result carries data")
   `PFBA_ASSERT_IMPLY(a_sweep_write, clock, reset, state_ff == S_SWEEP, map_wr_en && (map_wr_data == '1), "init pass not writing busy words")

endmodule

[verif/tb_page_frame_bitmap_allocator.sv]
`timescale 1ns / 100ps

module tb_page_frame_bitmap_allocator;
   import pfba_pkg::*;

   localparam int MAP_WORDS = MAP_WORDS_DEF;
   localparam int PAGE_SHIFT = PAGE_SHIFT_DEF;
   localparam int WORD_BITS = WORD_BITS_DEF;
   localparam longint unsigned PAGE_BYTES = 64'd1 << PAGE_SHIFT;
   localparam longint unsigned MAP_FRAMES = MAP_WORDS * WORD_BITS;
   localparam logic [ADDR_W-1:0] PAGE_SPAN = ADDR_W'(PAGE_BYTES);
   localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
   localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RSVD_LAST = 3'd7;
   localparam int PHASES = 5;
   localparam int PHASE_REQUESTS = 100;
   // a full 2^40-byte range walks every page with no handshake
   localparam int STALL_LIMIT = 2_200_000;
   localparam int DRAIN_CYCLES = 4 * MAP_WORDS;
   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      logic [CMD_W-1:0]       cmd;
      logic [ADDR_W-1:0]      base;
      logic [ADDR_W-1:0]      length;
      logic [FRAME_OUT_W-1:0] frame_in;
   } frame_req_type;

   typedef struct packed {
      logic [FRAME_OUT_W-1:0] frame;
      logic                   oom;
      logic [COUNT_W-1:0]     added;
      logic [COUNT_W-1:0]     total;
   } frame_rsp_type;

   typedef struct packed {
      frame_req_type req;
      logic          typed;
      frame_rsp_type want;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic [CMD_W-1:0]       req_cmd = '0;
   logic [ADDR_W-1:0]      req_range_base = '0;
   logic [ADDR_W-1:0]      req_range_length = '0;
   logic [FRAME_OUT_W-1:0] req_frame_in = '0;
   logic                   csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [ADDR_W-1:0]      csr_wdata = '0;
   logic                   busy;
   logic                   rsp_valid;
   logic [FRAME_OUT_W-1:0] rsp_frame_out;
   logic                   rsp_out_of_memory;
   logic [COUNT_W-1:0]     rsp_pages_added;
   logic [COUNT_W-1:0]     rsp_usable_total;
   logic                   csr_ready;

   // predictor state
   bit [WORD_BITS-1:0] busy_words [MAP_WORDS];
   bit [COUNT_W-1:0]   usable_pages;
   bit [ADDR_W-1:0]    kernel_lo;
   bit [ADDR_W-1:0]    kernel_hi;

   frame_rsp_type    expected_rsps[$];
   directed_row_type directed_rows[$];
   int               mismatch_count = 0;
   int               idle_cycles = 0;
   int               burst_left = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   page_frame_bitmap_allocator DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_range_base    (req_range_base),
      .req_range_length  (req_range_length),
      .req_frame_in      (req_frame_in),
      .rsp_valid         (rsp_valid),
      .rsp_frame_out     (rsp_frame_out),
      .rsp_out_of_memory (rsp_out_of_memory),
      .rsp_pages_added   (rsp_pages_added),
      .rsp_usable_total  (rsp_usable_total),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   function automatic void mark_all_busy();
      foreach (busy_words[w]) busy_words[w] = '1;
   endfunction

   function automatic void release_frame(longint unsigned f);
      if (f < MAP_FRAMES) busy_words[f / WORD_BITS][f % WORD_BITS] = 1'b0;
   endfunction

   function automatic bit page_usable(longint unsigned p);
      longint unsigned page_end;
      page_end = p + PAGE_BYTES;
      if (page_end >= kernel_lo && p < kernel_hi) return 1'b0;
      if (page_end >= HOLE_LOW && p < HOLE_HIGH) return 1'b0;
      return 1'b1;
   endfunction

   function automatic frame_rsp_type predict_page_frames(frame_req_type r);
      frame_rsp_type   e;
      longint unsigned limit;
      longint unsigned pg;
      longint unsigned found;
      bit              hit;
      e = '0;
      found = 0;
      hit = 1'b0;
      case (r.cmd)
         CMD_INIT: begin
            mark_all_busy();
            usable_pages = '0;
         end
         CMD_ADD_RANGE: begin
            // exact sums: the walk may run past the 40-bit address space
            limit = 64'(r.base) + 64'(r.length);
            if (64'(r.length) >= PAGE_BYTES) begin
               pg = (64'(r.base) + PAGE_BYTES - 1) & ~(PAGE_BYTES - 1);
               while (pg + PAGE_BYTES <= limit) begin
                  if (page_usable(pg)) begin
                     release_frame(pg >> PAGE_SHIFT);
                     found++;
                  end
                  pg += PAGE_BYTES;
               end
            end
            e.added = COUNT_W'(found);
            if (64'(usable_pages) + found > 64'(COUNT_MAX)) usable_pages = COUNT_MAX;
            else usable_pages += COUNT_W'(found);
         end
         CMD_ALLOC: begin
            for (int w = 0; w < MAP_WORDS && !hit; w++) begin
               for (int b = 0; b < WORD_BITS && !hit; b++) begin
                  if (!busy_words[w][b]) begin
                     busy_words[w][b] = 1'b1;
                     e.frame = FRAME_OUT_W'(w * WORD_BITS + b);
                     hit = 1'b1;
                  end
               end
            end
            e.oom = !hit;
         end
         CMD_FREE_ADDR: release_frame(64'(r.base) >> PAGE_SHIFT);
         CMD_FREE_FRAME: release_frame(64'(r.frame_in));
         default: ;
      endcase
      e.total = usable_pages;
      return e;
   endfunction

   function automatic void add_row(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] base,
                                   logic [ADDR_W-1:0] length, logic [FRAME_OUT_W-1:0] fin,
                                   bit typed = 1'b0, logic [FRAME_OUT_W-1:0] frame = '0,
                                   logic oom = 1'b0, logic [COUNT_W-1:0] added = '0,
                                   logic [COUNT_W-1:0] total = '0);
      directed_rows.push_back('{'{cmd, base, length, fin}, typed, '{frame, oom, added, total}});
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      return {8'($urandom()), 32'($urandom())};
   endfunction

   // range starts often cluster around the kernel window and the low edge of the I/O hole
   function automatic logic [ADDR_W-1:0] range_start();
      logic [ADDR_W-1:0] anchor;
      case ($urandom_range(0, 4))
         0: anchor = kernel_lo - ADDR_W'($urandom_range(0, 4) * PAGE_BYTES);
         1: anchor = kernel_hi - ADDR_W'($urandom_range(0, 4) * PAGE_BYTES);
         2: anchor = ADDR_W'(HOLE_LOW) - ADDR_W'($urandom_range(0, 8) * PAGE_BYTES);
         3: anchor = {7'd0, 1'($urandom()), 32'($urandom())};
         default: anchor = rand_addr();
      endcase
      if ($urandom_range(0, 1) == 0) anchor = anchor & ~(PAGE_SPAN - 1);
      else anchor = anchor + ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
      return anchor;
   endfunction

   function automatic frame_req_type random_request();
      frame_req_type r;
      int            pick;
      r.cmd = CMD_ALLOC;
      r.base = rand_addr();
      r.length = rand_addr();
      r.frame_in = FRAME_OUT_W'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         r.cmd = CMD_INIT;
      end else if (pick < 5) begin
         r.cmd = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
      end else if (pick < 30) begin
         r.cmd = CMD_ADD_RANGE;
         r.base = range_start();
         if ($urandom_range(0, 7) == 0) r.length = ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
         else r.length = ADDR_W'($urandom_range(1, 16) * PAGE_BYTES
                                  + $urandom_range(0, PAGE_BYTES - 1));
      end else if (pick < 65) begin
         r.cmd = CMD_ALLOC;
      end else if (pick < 82) begin
         r.cmd = CMD_FREE_FRAME;
      end else begin
         r.cmd = CMD_FREE_ADDR;
         // mostly addresses that land inside the map
         if ($urandom_range(0, 3) != 0)
            r.base = ADDR_W'((64'(r.frame_in) << PAGE_SHIFT)
                             | 64'($urandom_range(0, PAGE_BYTES - 1)));
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   task automatic issue_request(frame_req_type r, bit typed, frame_rsp_type want);
      int            gap;
      frame_rsp_type e;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = $urandom_range(0, 3);
         if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(8, 24);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= r.cmd;
      req_range_base <= r.base;
      req_range_length <= r.length;
      req_frame_in <= r.frame_in;
      do @(posedge clock); while (busy !== 1'b0);
      e = predict_page_frames(r);
      expected_rsps.push_back(typed ? want : e);
   endtask

   task automatic write_kernel_window(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
      csr_valid <= 1'b1;
      csr_index <= CSR_KERNEL_START;
      csr_wdata <= lo;
      do @(posedge clock); while (csr_ready !== 1'b1);
      kernel_lo = lo;
      csr_index <= CSR_KERNEL_END;
      csr_wdata <= hi;
      do @(posedge clock); while (csr_ready !== 1'b1);
      kernel_hi = hi;
      csr_valid <= 1'b0;
   endtask

   task automatic wait_responses();
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      frame_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("response with no request pending", rsp_frame_out, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_frame_out !== want.frame)
               report_mismatch("frame_out", rsp_frame_out, want.frame);
            if (rsp_out_of_memory !== want.oom)
               report_mismatch("out_of_memory", rsp_out_of_memory, want.oom);
            if (rsp_pages_added !== want.added)
               report_mismatch("pages_added", rsp_pages_added, want.added);
            if (rsp_usable_total !== want.total)
               report_mismatch("usable_total", rsp_usable_total, want.total);
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_page_frame_bitmap_allocator NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      mark_all_busy();
      usable_pages = '0;
      kernel_lo = '0;
      kernel_hi = '0;

      // after reset every frame is busy
      add_row(CMD_ALLOC, '0, '0, '0, 1, '0, 1, 0, 0);
      add_row(CMD_FREE_FRAME, '0, '0, '0, 1, '0, 0, 0, 0);
      add_row(CMD_ALLOC, '0, '0, '0, 1, '0, 0, 0, 0);
      // too short, or no whole page left after aligning up
      add_row(CMD_ADD_RANGE, '0, PAGE_SPAN - 1, '0, 1, '0, 0, 0, 0);
      add_row(CMD_ADD_RANGE, 40'd1, PAGE_SPAN, '0, 1, '0, 0, 0, 0);
      // page ending exactly at the range limit
      add_row(CMD_ADD_RANGE, '0, PAGE_SPAN, '0, 1, '0, 0, 1, 1);
      add_row(CMD_ALLOC, '0, '0, '0, 1, '0, 0, 0, 1);
      add_row(CMD_ADD_RANGE, 40'd1, 2 * PAGE_SPAN, '0, 1, '0, 0, 1, 2);
      add_row(CMD_ALLOC, '0, '0, '0, 1, 11'd1, 0, 0, 2);
      add_row(CMD_FREE_ADDR, PAGE_SPAN + 40'h1234, '0, '0, 1, '0, 0, 0, 2);
      add_row(CMD_FREE_ADDR, PAGE_SPAN + 40'h1234, '0, '0, 1, '0, 0, 0, 2);
      add_row(CMD_ALLOC, '0, '0, '0, 1, 11'd1, 0, 0, 2);
      add_row(CMD_FREE_FRAME, '0, '0, '1, 1, '0, 0, 0, 2);
      add_row(CMD_ALLOC, '0, '0, '0, 1, '1, 0, 0, 2);
      add_row(CMD_ALLOC, '0, '0, '0, 1, '0, 1, 0, 2);
      // frame far above the map whose low bits alias the top frame: ignored
      add_row(CMD_FREE_ADDR, ADDR_MAX, '0, '0, 1, '0, 0, 0, 2);
      add_row(CMD_ALLOC, '0, '0, '0, 1, '0, 1, 0, 2);
      add_row(CMD_ADD_RANGE, 40'hFE_0000_0000 >> 8, 8 * PAGE_SPAN, '0);
      add_row(CMD_RSVD_FIRST, ADDR_MAX, ADDR_MAX, '1);
      add_row(CMD_RSVD_LAST, ADDR_MAX, ADDR_MAX, '1);
      // pages above the map are counted only; the second walk crosses 2^40
      add_row(CMD_ADD_RANGE, ADDR_MAX - PAGE_SPAN + 1, PAGE_SPAN, '0);
      add_row(CMD_ADD_RANGE, ADDR_MAX, 3 * PAGE_SPAN, '0);
      // two full-space walks plus a small one drive the total into saturation
      add_row(CMD_ADD_RANGE, '0, ADDR_MAX, '0);
      add_row(CMD_ADD_RANGE, '0, ADDR_MAX, '0);
      add_row(CMD_ADD_RANGE, '0, 64 * PAGE_SPAN, '0);
      add_row(CMD_INIT, ADDR_MAX, ADDR_MAX, '1, 1, '0, 0, 0, 0);
      add_row(CMD_ALLOC, '0, '0, '0, 1, '0, 1, 0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      start <= 1'b0;
      wait_responses();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               // every page inside the 40-bit address space overlaps the kernel window
               lo = '0;
               hi = ADDR_MAX;
            end
            1: begin
               lo = ADDR_MAX;
               hi = '0;
            end
            2, 3: begin
               lo = ADDR_W'(64'($urandom_range(0, MAP_FRAMES - 1)) * PAGE_BYTES
                            + $urandom_range(0, PAGE_BYTES - 1));
               hi = lo + ADDR_W'($urandom_range(0, 64) * PAGE_BYTES
                                 + $urandom_range(0, PAGE_BYTES - 1));
            end
            default: begin
               lo = rand_addr();
               hi = rand_addr();
            end
         endcase
         write_kernel_window(lo, hi);
         repeat (PHASE_REQUESTS) issue_request(random_request(), 1'b0, '0);
         start <= 1'b0;
         wait_responses();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("tb_page_frame_bitmap_allocator OK");
      end else begin
         $display("tb_page_frame_bitmap_allocator NOT OK");
      end
      $finish;
   end

endmodule
